### hw/rtl/matrix_multiply_engine_assert.svh
// ---------------------------------------------------------------------------
// matrix_multiply_engine_assert
// assertion macros shared by the matrix multiply engine
// ---------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_ASSERT_SVH

// consequent checked in the same cycle
`define MME_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define MME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mme_pkg.sv
// ---------------------------------------------------------------------------
// mme_pkg
// types and constants of the matrix multiply engine
// ---------------------------------------------------------------------------
package mme_pkg;

  localparam int VALUE_W       = 16;
  localparam int PRODUCT_W     = 35;
  localparam int COLUMN_W      = 3;
  localparam int CFG_W         = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int MAX_DIM_DEF   = 8;
  localparam int ELEM_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS   = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     CFG_DIM_RESET  = CFG_W'(8);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_ROW  = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic signed [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [PRODUCT_W-1:0] product;
    logic [COLUMN_W-1:0]         column;
    logic                        row_end;
  } out_word_t;

  typedef struct packed {
    logic is_row;
    logic last;
  } mme_q_ctrl_t;

  typedef struct packed {
    logic hold;
    logic s2_row_end;
  } mme_back_status_t;

endpackage

### hw/rtl/mme_front.sv
// ---------------------------------------------------------------------------
// mme_front
// takes input words and config writes, tracks load and row positions and
// queues each word with its store address
// ---------------------------------------------------------------------------
module mme_front import mme_pkg::*; #(
  parameter  int MAX_DIM   = MAX_DIM_DEF,
  parameter  int ELEM_BITS = ELEM_BITS_DEF,
  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int AW        = 2 * IDX_W,
  localparam int CNT_W     = IDX_W + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  input  logic                 q_full,
  output logic                 q_push,
  output mme_q_ctrl_t          q_ctrl,
  output logic [AW-1:0]        q_addr,
  output logic [ELEM_BITS-1:0] q_value,
  output logic [CNT_W-1:0]     q_cols
);

  logic [CFG_W-1:0]   inner_r, inner_nxt;
  logic [CFG_W-1:0]   cols_r, cols_nxt;
  logic [AW-1:0]      lp_r, lp_nxt;
  logic [IDX_W-1:0]   ip_r, ip_nxt;
  logic [CNT_W-1:0]   inner_c, cols_c;
  logic [2*CNT_W-1:0] total, lp_inc;
  logic [CNT_W-1:0]   ip_inc;
  logic               row_last, is_row;
  logic [AW-1:0]      base;

  function automatic logic [CNT_W-1:0] clamp_dim(logic [CFG_W-1:0] r);
    if (r == '0) begin
      return CNT_W'(1);
    end else if (r > CFG_W'(MAX_DIM)) begin
      return CNT_W'(MAX_DIM);
    end else begin
      return CNT_W'(r);
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;

  always_comb begin
    inner_c  = clamp_dim(inner_r);
    cols_c   = clamp_dim(cols_r);
    total    = (2*CNT_W)'(inner_c) * (2*CNT_W)'(cols_c);
    lp_inc   = (2*CNT_W)'(lp_r) + (2*CNT_W)'(1);
    ip_inc   = CNT_W'(ip_r) + CNT_W'(1);
    row_last = ip_inc >= inner_c;
    base     = AW'(ip_r) * AW'(cols_c);
    is_row   = in_data.mode == MODE_ROW;
  end

  always_comb begin
    q_ctrl.is_row = is_row;
    q_ctrl.last   = row_last;
    q_addr        = is_row ? base : lp_r;
    q_value       = ELEM_BITS'($unsigned(in_data.value));
    q_cols        = cols_c;
  end

  always_comb begin
    inner_nxt = inner_r;
    cols_nxt  = cols_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_INNER_SIZE: inner_nxt = cfg_data;
        CFG_OUT_COLS:   cols_nxt  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    lp_nxt = lp_r;
    ip_nxt = ip_r;
    if (q_push) begin
      if (is_row) begin
        ip_nxt = row_last ? '0 : ip_inc[IDX_W-1:0];
      end else begin
        lp_nxt = (lp_inc >= total) ? '0 : lp_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= CFG_DIM_RESET;
      cols_r  <= CFG_DIM_RESET;
      lp_r    <= '0;
      ip_r    <= '0;
    end else begin
      inner_r <= inner_nxt;
      cols_r  <= cols_nxt;
      lp_r    <= lp_nxt;
      ip_r    <= ip_nxt;
    end
  end

endmodule

### hw/rtl/mme_queue.sv
// ---------------------------------------------------------------------------
// mme_queue
// short first-in first-out queue between front and back
// ---------------------------------------------------------------------------
module mme_queue import mme_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;

  assign full  = count_r == (PW+1)'(QUEUE_DEPTH);
  assign valid = count_r != '0;
  assign rdata = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### hw/rtl/mme_back.sv
// ---------------------------------------------------------------------------
// mme_back
// banked weight store, per-column multipliers, accumulators and the
// product row buffer that drains one word per cycle while out_stall is low
// ---------------------------------------------------------------------------
module mme_back import mme_pkg::*; #(
  parameter  int MAX_DIM   = MAX_DIM_DEF,
  parameter  int ELEM_BITS = ELEM_BITS_DEF,
  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int AW        = 2 * IDX_W,
  localparam int CNT_W     = IDX_W + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  mme_q_ctrl_t          q_ctrl,
  input  logic [AW-1:0]        q_addr,
  input  logic [ELEM_BITS-1:0] q_value,
  input  logic [CNT_W-1:0]     q_cols,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  output mme_back_status_t     status
);

  localparam int NB     = 2 ** IDX_W;
  localparam int MUL_W  = 2 * ELEM_BITS;
  localparam int EXT_W  = (MUL_W > PRODUCT_W) ? MUL_W : PRODUCT_W;

  logic                 hold, wr, rd, load, emit, out_end;
  logic [ELEM_BITS-1:0] bank_q [NB];
  logic [AW-IDX_W-1:0]  rrow   [NB];
  logic [IDX_W-1:0]     lane_sel [NB];

  logic                 s1_v_r;
  logic [ELEM_BITS-1:0] s1_value_r;
  logic [IDX_W-1:0]     s1_low_r;
  logic                 s1_last_r;
  logic [CNT_W-1:0]     s1_cols_r;

  logic                    s2_v_r;
  logic                    s2_last_r;
  logic [CNT_W-1:0]        s2_cols_r;
  logic signed [MUL_W-1:0] prod_r [NB];

  logic [PRODUCT_W-1:0] acc_r [NB];
  logic [PRODUCT_W-1:0] acc_nxt [NB];
  logic [PRODUCT_W-1:0] sum [NB];
  logic [PRODUCT_W-1:0] buf_r [NB];
  logic                 busy_r, busy_nxt;
  logic [IDX_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     ncols_r;

  assign out_end = (CNT_W'(cnt_r) + CNT_W'(1)) == ncols_r;
  assign emit    = busy_r && !out_stall;
  assign hold    = s2_v_r && s2_last_r && busy_r && !(emit && out_end);
  assign q_pop   = q_valid && !hold;
  assign wr      = q_pop && !q_ctrl.is_row;
  assign rd      = q_pop && q_ctrl.is_row;
  assign load    = s2_v_r && s2_last_r && !hold;

  always_comb begin
    logic [IDX_W-1:0] lane;
    logic [AW-1:0]    raddr;
    for (int b = 0; b < NB; b++) begin
      lane        = IDX_W'(b) - q_addr[IDX_W-1:0];
      raddr       = q_addr + AW'(lane);
      rrow[b]     = raddr[AW-1:IDX_W];
      lane_sel[b] = s1_low_r + IDX_W'(b);
    end
  end

  for (genvar b = 0; b < NB; b++) begin : g_bank
    logic [ELEM_BITS-1:0] mem [NB];
    logic [ELEM_BITS-1:0] rd_r;

    always_ff @(posedge clk) begin
      if (wr && (q_addr[IDX_W-1:0] == IDX_W'(b))) begin
        mem[q_addr[AW-1:IDX_W]] <= q_value;
      end
      if (rd) begin
        rd_r <= mem[rrow[b]];
      end
    end

    assign bank_q[b] = rd_r;
  end

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!hold) begin
      s1_v_r <= rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd) begin
      s1_value_r <= q_value;
      s1_low_r   <= q_addr[IDX_W-1:0];
      s1_last_r  <= q_ctrl.last;
      s1_cols_r  <= q_cols;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (!hold) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && s1_v_r) begin
      s2_last_r <= s1_last_r;
      s2_cols_r <= s1_cols_r;
      for (int j = 0; j < NB; j++) begin
        prod_r[j] <= $signed(s1_value_r) * $signed(bank_q[lane_sel[j]]);
      end
    end
  end

  // accumulate stage
  always_comb begin
    logic signed [EXT_W-1:0] p_ext;
    for (int j = 0; j < NB; j++) begin
      p_ext = EXT_W'(prod_r[j]);
      if (CNT_W'(j) < s2_cols_r) begin
        sum[j] = acc_r[j] + p_ext[PRODUCT_W-1:0];
      end else begin
        sum[j] = acc_r[j];
      end
      acc_nxt[j] = acc_r[j];
      if (s2_v_r && !hold) begin
        acc_nxt[j] = s2_last_r ? '0 : sum[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NB; j++) begin
        acc_r[j] <= '0;
      end
    end else begin
      for (int j = 0; j < NB; j++) begin
        acc_r[j] <= acc_nxt[j];
      end
    end
  end

  // product row buffer
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (emit) begin
      if (out_end) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ncols_r <= s2_cols_r;
      for (int j = 0; j < NB; j++) begin
        buf_r[j] <= sum[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_comb begin
    out_valid         = busy_r;
    out_data.product  = buf_r[cnt_r];
    out_data.column   = COLUMN_W'(cnt_r);
    out_data.row_end  = out_end;
    status.hold       = hold;
    status.s2_row_end = s2_v_r && s2_last_r;
  end

endmodule

### hw/rtl/matrix_multiply_engine.sv
// ---------------------------------------------------------------------------
// matrix_multiply_engine
// streaming fixed point matrix product, weight matrix held in a banked store
// ---------------------------------------------------------------------------
//  channel | direction | handshake         | word
//  in_     | input     | in_valid/in_stall | mode, value (b load or a element)
//  out_    | output    | out_valid/stall   | product, column, row_end
//  cfg_    | input     | cfg_valid/ready   | cfg_index, cfg_data
//
//  one input word per cycle is taken while the four-word queue has room
//  a row of the product drains from the row buffer at one word per cycle
//  while out_stall is low
//  the last a element of a row reaches the output through the queue, the
//  store read, the multiply and the accumulate into the row buffer
//  synchronous reset clears pointers, accumulators, queue count and the row
//  buffer's busy state; the weight store and buffered data are not cleared
//  the back stalls at a row end while the previous row is still draining
// ---------------------------------------------------------------------------
`include "matrix_multiply_engine_assert.svh"

module matrix_multiply_engine import mme_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data
);

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW    = 2 * IDX_W;
  localparam int CNT_W = IDX_W + 1;
  localparam int Q_W   = $bits(mme_q_ctrl_t) + AW + ELEM_BITS + CNT_W;

  logic                 q_push, q_full, q_pop, q_valid;
  mme_q_ctrl_t          qi_ctrl, qo_ctrl;
  logic [AW-1:0]        qi_addr, qo_addr;
  logic [ELEM_BITS-1:0] qi_value, qo_value;
  logic [CNT_W-1:0]     qi_cols, qo_cols;
  logic [Q_W-1:0]       q_wdata, q_rdata;
  mme_back_status_t     status;

  mme_front #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ctrl    (qi_ctrl),
    .q_addr    (qi_addr),
    .q_value   (qi_value),
    .q_cols    (qi_cols)
  );

  assign q_wdata = {qi_ctrl, qi_addr, qi_value, qi_cols};
  assign {qo_ctrl, qo_addr, qo_value, qo_cols} = q_rdata;

  mme_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  mme_back #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_ctrl    (qo_ctrl),
    .q_addr    (qo_addr),
    .q_value   (qo_value),
    .q_cols    (qo_cols),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (status)
  );

  `MME_ASSERT_SAME(a_hold_blocks_pop, status.hold, status.s2_row_end && !q_pop, "pop during hold")
  `MME_ASSERT_SAME(a_pop_needs_word, q_pop, q_valid, "pop from empty queue")
  `MME_ASSERT_NEXT(a_push_lands, in_valid && !in_stall, q_valid, "pushed word missing")

endmodule
